// ===== src/mpq_pkg.sv =====
// Shared types and constants for the max priority queue.
package mpq_pkg;

    localparam int DEPTH     = 128;
    localparam int ID_BITS   = 16;
    localparam int PRIO_BITS = 8;
    localparam int OCC_BITS  = 8;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    typedef struct packed {
        logic                 mode;
        logic [ID_BITS-1:0]   proc_id;
        logic [PRIO_BITS-1:0] prio;
    } t_in_item;

    typedef struct packed {
        logic [1:0]           status;
        logic [ID_BITS-1:0]   out_id;
        logic [PRIO_BITS-1:0] out_prio;
        logic [OCC_BITS-1:0]  occupancy;
    } t_out_item;

    typedef struct packed {
        logic [ID_BITS-1:0]   id;
        logic [PRIO_BITS-1:0] prio;
    } t_entry;

    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_ctl;

endpackage

// ===== src/mpq_cell.sv =====
// One slot of the sorted chain: holds an entry, shifts right on insert, left on remove.
module mpq_cell (
    input  logic              i_clk,
    input  mpq_pkg::t_cell_ctl i_ctl,
    input  logic              i_occupied,
    input  mpq_pkg::t_entry   i_new,
    input  mpq_pkg::t_entry   i_prev,
    input  logic              i_prev_keep,
    input  mpq_pkg::t_entry   i_next,
    output mpq_pkg::t_entry   o_entry,
    output logic              o_keep
);

    mpq_pkg::t_entry r_entry;
    mpq_pkg::t_entry n_entry;

    // keep the entry when it ranks at or above the new one (ties stay ahead)
    assign o_keep  = i_occupied && (r_entry.prio >= i_new.prio);
    assign o_entry = r_entry;

    // pick the next entry: hold, take the new entry, or take a neighbor's
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins && !o_keep) begin
            n_entry = i_prev_keep ? i_new : i_prev;
        end else if (i_ctl.rem) begin
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ===== src/max_priority_queue.sv =====
// Top level of the max priority queue built as a sorted chain of cells.
// Each item is accepted and its result appears in the output register on the
// next cycle; one item per cycle is sustained while the receiver does not
// stall the output, as every cell in the chain shifts at once.
// Reset (synchronous, active low) empties the queue and clears the output valid;
// the cell contents are left as they are and only occupied cells are read.
module max_priority_queue #(
    parameter int DEPTH = mpq_pkg::DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mpq_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mpq_pkg::t_out_item  o_out_item
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_out_valid;
    mpq_pkg::t_out_item r_out_item;
    mpq_pkg::t_out_item n_out_item;

    logic               accept;
    logic               is_full;
    logic               is_empty;
    mpq_pkg::t_cell_ctl ctl;
    mpq_pkg::t_entry    new_entry;
    mpq_pkg::t_entry    cell_entry [DEPTH];
    logic               cell_keep  [DEPTH];

    // accept an item whenever the output register is free or being drained
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign is_full    = (r_count == CNT_W'(DEPTH));
    assign is_empty   = (r_count == '0);

    assign ctl.ins = accept && (i_in_item.mode == mpq_pkg::MODE_INSERT) && !is_full;
    assign ctl.rem = accept && (i_in_item.mode == mpq_pkg::MODE_REMOVE) && !is_empty;

    assign new_entry.id   = i_in_item.proc_id;
    assign new_entry.prio = i_in_item.prio;

    // build the chain; the head cell always holds the best entry
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        mpq_pkg::t_entry prev_entry;
        mpq_pkg::t_entry next_entry;
        logic            prev_keep;

        if (gi == 0) begin : g_head
            assign prev_entry = new_entry;
            assign prev_keep  = 1'b1;
        end else begin : g_body
            assign prev_entry = cell_entry[gi-1];
            assign prev_keep  = cell_keep[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_tail
            assign next_entry = cell_entry[gi];
        end else begin : g_inner
            assign next_entry = cell_entry[gi+1];
        end

        mpq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_occupied  (CNT_W'(gi) < r_count),
            .i_new       (new_entry),
            .i_prev      (prev_entry),
            .i_prev_keep (prev_keep),
            .i_next      (next_entry),
            .o_entry     (cell_entry[gi]),
            .o_keep      (cell_keep[gi])
        );
    end

    // update the entry count and form the result of this item
    always_comb begin
        n_count              = r_count;
        n_out_item.status    = mpq_pkg::ST_OK;
        n_out_item.out_id    = '0;
        n_out_item.out_prio  = '0;
        if (i_in_item.mode == mpq_pkg::MODE_INSERT) begin
            if (is_full) begin
                n_out_item.status = mpq_pkg::ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if (is_empty) begin
                n_out_item.status = mpq_pkg::ST_EMPTY;
            end else begin
                n_count             = r_count - CNT_W'(1);
                n_out_item.out_id   = cell_entry[0].id;
                n_out_item.out_prio = cell_entry[0].prio;
            end
        end
        n_out_item.occupancy = mpq_pkg::OCC_BITS'(n_count);
    end

    // clear count and output valid under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // load the result payload with each accepted item
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== sim/max_priority_queue_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the max priority queue.
module max_priority_queue_tb;

    localparam int    CLK_HALF_NS = 1;
    localparam int    RESET_CYCLES = 6;
    localparam int    DRAIN_CYCLES = 8;
    localparam time   RUN_LIMIT = 5_000_000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    mpq_pkg::t_in_item  i_in_item = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    mpq_pkg::t_out_item o_out_item;

    // Predicted queue contents in insertion order, and results still owed
    mpq_pkg::t_entry    held_entries[$];
    mpq_pkg::t_out_item expected_results[$];

    bit        idle_on = 1'b1;
    int        error_count = 0;
    int        result_count = 0;
    int        insert_count = 0;
    int        full_count = 0;
    int        remove_count = 0;
    int        empty_count = 0;
    int        peak_occupancy = 0;

    max_priority_queue uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

    initial begin
        forever #(CLK_HALF_NS) i_clk = ~i_clk;
    end

    // Mostly no gap (none at all when idle_on is off), some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 20);
    endfunction

    function automatic mpq_pkg::t_in_item make_op(logic mode,
                                                  logic [mpq_pkg::ID_BITS-1:0] id,
                                                  logic [mpq_pkg::PRIO_BITS-1:0] prio);
        mpq_pkg::t_in_item item;
        item.mode    = mode;
        item.proc_id = id;
        item.prio    = prio;
        return item;
    endfunction

    // Mix wide priorities with narrow bands so ties and extremes show up often
    function automatic logic [mpq_pkg::PRIO_BITS-1:0] rand_prio();
        case ($urandom_range(0, 3))
            0: return mpq_pkg::PRIO_BITS'($urandom_range(0, 255));
            1: return mpq_pkg::PRIO_BITS'($urandom_range(0, 3));
            2: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: return mpq_pkg::PRIO_BITS'($urandom_range(250, 255));
        endcase
    endfunction

    function automatic mpq_pkg::t_in_item rand_op(int insert_pct);
        logic mode;
        mode = ($urandom_range(1, 100) <= insert_pct) ? mpq_pkg::MODE_INSERT
                                                      : mpq_pkg::MODE_REMOVE;
        return make_op(mode, mpq_pkg::ID_BITS'($urandom_range(0, 16'hFFFF)), rand_prio());
    endfunction

    // Apply one operation to the predicted queue and return the expected result
    function automatic mpq_pkg::t_out_item predict_queue_op(mpq_pkg::t_in_item item);
        mpq_pkg::t_out_item res;
        int                 best;
        res = '0;
        res.status = mpq_pkg::ST_OK;
        if (item.mode == mpq_pkg::MODE_INSERT) begin
            if (held_entries.size() >= mpq_pkg::DEPTH) begin
                res.status = mpq_pkg::ST_FULL;
                full_count++;
            end else begin
                held_entries.push_back('{id: item.proc_id, prio: item.prio});
                insert_count++;
            end
        end else begin
            if (held_entries.size() == 0) begin
                res.status = mpq_pkg::ST_EMPTY;
                empty_count++;
            end else begin
                // Strict compare keeps the earliest entry among equal priorities
                best = 0;
                for (int k = 1; k < held_entries.size(); k++) begin
                    if (held_entries[k].prio > held_entries[best].prio) begin
                        best = k;
                    end
                end
                res.out_id   = held_entries[best].id;
                res.out_prio = held_entries[best].prio;
                held_entries.delete(best);
                remove_count++;
            end
        end
        res.occupancy = mpq_pkg::OCC_BITS'(held_entries.size());
        if (held_entries.size() > peak_occupancy) begin
            peak_occupancy = held_entries.size();
        end
        return res;
    endfunction

    // Drive one item, hold it until accepted, then record its expected result
    task automatic send_item(mpq_pkg::t_in_item item);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= item;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        expected_results.push_back(predict_queue_op(item));
    endtask

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch in result %0d: %s got 0x%0h, expected 0x%0h",
                 result_count, field, got, want);
        error_count++;
    endtask

    // Receiver backpressure
    always @(posedge i_clk) begin
        int stall_left;
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            stall_left = pick_gap();
        end
    end

    // Compare each accepted result against the oldest prediction
    always @(posedge i_clk) begin
        mpq_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected item", 32'(o_out_item.status), 32'd0);
            end else begin
                want = expected_results.pop_front();
                if (o_out_item.status !== want.status) begin
                    report_mismatch("status", 32'(o_out_item.status), 32'(want.status));
                end
                if (o_out_item.out_id !== want.out_id) begin
                    report_mismatch("out_id", 32'(o_out_item.out_id), 32'(want.out_id));
                end
                if (o_out_item.out_prio !== want.out_prio) begin
                    report_mismatch("out_prio", 32'(o_out_item.out_prio),
                                    32'(want.out_prio));
                end
                if (o_out_item.occupancy !== want.occupancy) begin
                    report_mismatch("occupancy", 32'(o_out_item.occupancy),
                                    32'(want.occupancy));
                end
            end
            result_count++;
        end
    end

    // Remove from an empty queue, with the ignored fields set
    task automatic test_empty_remove();
        send_item(make_op(mpq_pkg::MODE_REMOVE, 16'hFFFF, 8'hFF));
        send_item(make_op(mpq_pkg::MODE_REMOVE, 16'h0000, 8'h00));
    endtask

    // Field extremes and alternating bit patterns
    task automatic test_field_extremes();
        send_item(make_op(mpq_pkg::MODE_INSERT, 16'h0000, 8'h00));
        send_item(make_op(mpq_pkg::MODE_INSERT, 16'hFFFF, 8'hFF));
        send_item(make_op(mpq_pkg::MODE_INSERT, 16'h5555, 8'hAA));
        send_item(make_op(mpq_pkg::MODE_INSERT, 16'hAAAA, 8'h55));
        repeat (5) send_item(make_op(mpq_pkg::MODE_REMOVE, 16'hA5A5, 8'h5A));
    endtask

    // Equal priorities come out in insertion order
    task automatic test_priority_ties();
        for (int k = 1; k <= 4; k++) begin
            send_item(make_op(mpq_pkg::MODE_INSERT, mpq_pkg::ID_BITS'(k), 8'd7));
        end
        send_item(make_op(mpq_pkg::MODE_INSERT, 16'd5, 8'd9));
        send_item(make_op(mpq_pkg::MODE_INSERT, 16'd6, 8'd7));
        repeat (6) send_item(make_op(mpq_pkg::MODE_REMOVE, 16'h0, 8'h0));
    endtask

    task automatic test_random_mix(int count);
        repeat (count) send_item(rand_op(55));
    endtask

    // Fill to capacity, then push against the full queue
    task automatic test_fill_to_full();
        while (held_entries.size() < mpq_pkg::DEPTH) begin
            send_item(rand_op(85));
        end
        repeat (4) send_item(rand_op(100));
    endtask

    // Drain to empty, then pull from the empty queue
    task automatic test_drain_to_empty();
        while (held_entries.size() > 0) begin
            send_item(rand_op(15));
        end
        repeat (4) send_item(rand_op(0));
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_remove();
        test_field_extremes();
        test_priority_ties();
        for (int round = 0; round < 2; round++) begin
            idle_on = (round == 0);
            test_random_mix(150);
            test_fill_to_full();
            test_drain_to_empty();
        end
        i_in_valid <= 1'b0;

        // Hold until every result is back, then let the pipeline settle
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d inserts (%0d refused as full) and %0d removes (%0d on empty).",
                 insert_count, full_count, remove_count, empty_count);
        $display("Checked %0d results, peak occupancy %0d of %0d.",
                 result_count, peak_occupancy, mpq_pkg::DEPTH);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT);
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
